// ----- rtl/fgn_pkg.sv -----
// Shared constants and payload types for the fractal gradient noise unit.
package fgn_pkg;

  // Default sizing
  localparam int unsigned MAX_OCTAVES_DEF = 8;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // Q.16 arithmetic
  localparam int ONE_Q16     = 65536;
  localparam int TOTAL_LIMIT = 16 * ONE_Q16;
  localparam int SHADE_SCALE = 127;
  localparam int SHADE_MAX   = 255;

  // Amplitude cutoff: amp * 1000 > 1.0  <=>  amp > floor(65536 / 1000)
  localparam int AMP_MIN = ONE_Q16 / 1000;

  // Lattice hash
  localparam logic [31:0] HASH_MUL = 32'd15731;
  localparam logic [31:0] HASH_ADD = 32'd789221;
  localparam logic [31:0] HASH_OFS = 32'd1376312589;
  localparam logic [31:0] GRAD_Y_OFS = 32'd100000;
  localparam int unsigned ROW_SHIFT = 10;

  // Index offsets of the four corners: (0,0) (1,0) (0,1) (1,1)
  localparam logic [31:0] CORNER_OFS [4] = '{32'd0, 32'd1, 32'd1024, 32'd1025};

  // Quintic fade 6t^5 - 15t^4 + 10t^3
  localparam int FADE_A = 6;
  localparam int FADE_B = 15 * ONE_Q16;
  localparam int FADE_C = 10 * ONE_Q16;

  // Datapath widths
  localparam int unsigned FADE_W  = 17;  // 0 .. 1.0
  localparam int unsigned GRAD_W  = 18;  // -65535 .. 65536
  localparam int unsigned NOISE_W = 20;  // corner values and blends

  // Configuration
  localparam int unsigned CFG_DATA_W   = 17;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam logic [16:0] PERSIST_RESET = 17'd39322;
  localparam logic [3:0]  OCTAVES_RESET = 4'd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PERSISTENCE  = 2'd0,
    CFG_OCTAVE_COUNT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] x_coord;
    logic [31:0] y_coord;
  } pt_t;

  typedef struct packed {
    logic signed [21:0] noise_total;
    logic [7:0]         shade;
  } res_t;

endpackage

// ----- rtl/fractal_gradient_noise_2d_unit.sv -----
// Fractal 2D gradient noise unit: Q16.16 point in, saturated octave sum and shade byte out.
//
// Each accepted word is a pair of unsigned fixed-point coordinates; each result word
// carries the fractal noise sum (signed Q5.16, saturated to +-16.0) and a shade byte
// floor((total + 1) * 127) clamped to 0..255. The datapath is a row of MAX_OCTAVES
// identical octave cells, each fully pipelined over 12 stages, so the unit takes one
// word every cycle unless the result side stalls, and passes it through (input register,
// cells, saturation stage, output register). Cell i samples the noise at the point
// scaled by 2^i, which it passes on shifted one place to the next cell together
// with the running sum and amplitude. An octave contributes only while its index is
// below octave_count and the amplitude is above 0.001; once cut off, later cells
// pass the sum through. The output register decouples the result side: a stall
// there holds the row only while the stage behind it is occupied.
// Configuration: index 0 persistence (unsigned Q1.16, 17 bits), index 1 octave_count
// (4 bits); other indices are ignored. Writes are always taken and must only be made
// while no word is in flight.
module fractal_gradient_noise_2d_unit #(
  parameter int unsigned MAX_OCTAVES = fgn_pkg::MAX_OCTAVES_DEF,
  parameter int unsigned FRAC_BITS   = fgn_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pt_valid,
  output logic                               pt_ready,
  input  fgn_pkg::pt_t                       pt,
  output logic                               res_valid,
  input  logic                               res_ready,
  output fgn_pkg::res_t                      res,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fgn_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fgn_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fgn_pkg::*;

  localparam int unsigned COORD_W = FRAC_BITS + 32;
  // Amplitude at most doubles per octave
  localparam int unsigned AMP_W   = 17 + MAX_OCTAVES;
  // Room for up to sixteen weighted terms
  localparam int unsigned TOTAL_W = AMP_W + 9;

  logic [16:0] persistence;
  logic [3:0]  octave_count;

  logic adv;
  logic out_load;

  // Chain between cells; entry 0 is the input register
  logic                      vch [MAX_OCTAVES+1];
  logic [COORD_W-1:0]        xch [MAX_OCTAVES+1];
  logic [COORD_W-1:0]        ych [MAX_OCTAVES+1];
  logic signed [TOTAL_W-1:0] tch [MAX_OCTAVES+1];
  logic [AMP_W-1:0]          ach [MAX_OCTAVES+1];
  logic                      rch [MAX_OCTAVES+1];

  logic                      in_vld;
  logic [COORD_W-1:0]        in_x;
  logic [COORD_W-1:0]        in_y;

  logic                      sat_vld;
  logic signed [21:0]        sat_total;
  logic signed [21:0]        sat_next;
  logic signed [29:0]        sh;
  logic [7:0]                shade_next;

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      persistence  <= PERSIST_RESET;
      octave_count <= OCTAVES_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PERSISTENCE:  persistence  <= cfg_data[16:0];
        CFG_OCTAVE_COUNT: octave_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Flow control: the row advances unless a finished word would be overwritten
  assign out_load = !res_valid || res_ready;
  assign adv      = out_load || !sat_vld;
  assign pt_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (adv) begin
      in_vld <= pt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_x <= COORD_W'(pt.x_coord);
      in_y <= COORD_W'(pt.y_coord);
    end
  end

  assign vch[0] = in_vld;
  assign xch[0] = in_x;
  assign ych[0] = in_y;
  assign tch[0] = '0;
  assign ach[0] = AMP_W'(ONE_Q16);
  assign rch[0] = 1'b1;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    fgn_cell #(
      .IDX       (i),
      .FRAC_BITS (FRAC_BITS),
      .COORD_W   (COORD_W),
      .AMP_W     (AMP_W),
      .TOTAL_W   (TOTAL_W)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .adv          (adv),
      .persistence  (persistence),
      .octave_count (octave_count),
      .valid_in     (vch[i]),
      .x_in         (xch[i]),
      .y_in         (ych[i]),
      .total_in     (tch[i]),
      .amp_in       (ach[i]),
      .run_in       (rch[i]),
      .valid_out    (vch[i+1]),
      .x_out        (xch[i+1]),
      .y_out        (ych[i+1]),
      .total_out    (tch[i+1]),
      .amp_out      (ach[i+1]),
      .run_out      (rch[i+1])
    );
  end

  // Saturate to +-16.0
  always_comb begin
    if (tch[MAX_OCTAVES] > TOTAL_W'(TOTAL_LIMIT)) begin
      sat_next = 22'(TOTAL_LIMIT);
    end else if (tch[MAX_OCTAVES] < -TOTAL_W'(TOTAL_LIMIT)) begin
      sat_next = -22'(TOTAL_LIMIT);
    end else begin
      sat_next = 22'(tch[MAX_OCTAVES]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_vld <= 1'b0;
    end else if (adv) begin
      sat_vld <= vch[MAX_OCTAVES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sat_total <= sat_next;
    end
  end

  // Shade byte
  assign sh = (30'(sat_total) + 30'(ONE_Q16)) * 30'(SHADE_SCALE);

  always_comb begin
    if (sh < 0) begin
      shade_next = 8'd0;
    end else if ((sh >>> 16) > 30'(SHADE_MAX)) begin
      shade_next = 8'(SHADE_MAX);
    end else begin
      shade_next = 8'(sh >>> 16);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= sat_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.noise_total <= sat_total;
      res.shade       <= shade_next;
    end
  end

endmodule

// ----- rtl/fgn_hash.sv -----
// Three-stage lattice hash giving one gradient value per corner index.
module fgn_hash (
  input  logic                             clk,
  input  logic                             adv,
  input  logic [31:0]                      idx,
  output logic signed [fgn_pkg::GRAD_W-1:0] grad
);
  import fgn_pkg::*;

  logic [31:0] nx;
  logic [31:0] n1;
  logic [31:0] sq;
  logic [31:0] n2;
  logic [31:0] tw;
  logic [31:0] h;

  assign nx = (idx << 13) ^ idx;
  assign h  = n2 * tw + HASH_OFS;

  always_ff @(posedge clk) begin
    if (adv) begin
      n1   <= nx;
      sq   <= nx * nx;
      n2   <= n1;
      tw   <= sq * HASH_MUL + HASH_ADD;
      grad <= GRAD_W'(ONE_Q16) - $signed({1'b0, h[30:14]});
    end
  end

endmodule

// ----- rtl/fgn_fade.sv -----
// Three-stage quintic fade curve on a Q.16 fraction.
module fgn_fade (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [fgn_pkg::FADE_W-1:0]  k,
  output logic [fgn_pkg::FADE_W-1:0]  f
);
  import fgn_pkg::*;

  logic signed [21:0] a;
  logic signed [39:0] ap;
  logic signed [39:0] tq;
  logic [FADE_W-1:0]  ka;
  logic [FADE_W-1:0]  sq;
  logic [FADE_W-1:0]  k3;
  logic [19:0]        tw;
  logic [19:0]        tw2;

  // t = floor(k*(6k-15)) + 10, always positive on 0..1
  assign a  = $signed({5'b0, k}) * 22'(FADE_A) - 22'(FADE_B);
  assign ap = 40'(a) * $signed({23'b0, k});
  assign tq = (ap >>> 16) + 40'(FADE_C);

  always_ff @(posedge clk) begin
    if (adv) begin
      ka  <= k;
      sq  <= FADE_W'((34'(k) * 34'(k)) >> 16);
      tw  <= tq[19:0];
      k3  <= FADE_W'((34'(sq) * 34'(ka)) >> 16);
      tw2 <= tw;
      f   <= FADE_W'((37'(k3) * 37'(tw2)) >> 16);
    end
  end

endmodule

// ----- rtl/fgn_cell.sv -----
// One octave cell: noise at its scaled coordinate, weighted and added to the running sum.
module fgn_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned FRAC_BITS = fgn_pkg::FRAC_BITS_DEF,
  parameter int unsigned COORD_W   = fgn_pkg::FRAC_BITS_DEF + 32,
  parameter int unsigned AMP_W     = 17 + fgn_pkg::MAX_OCTAVES_DEF,
  parameter int unsigned TOTAL_W   = 26 + fgn_pkg::MAX_OCTAVES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic [16:0]               persistence,
  input  logic [3:0]                octave_count,
  input  logic                      valid_in,
  input  logic [COORD_W-1:0]        x_in,
  input  logic [COORD_W-1:0]        y_in,
  input  logic signed [TOTAL_W-1:0] total_in,
  input  logic [AMP_W-1:0]          amp_in,
  input  logic                      run_in,
  output logic                      valid_out,
  output logic [COORD_W-1:0]        x_out,
  output logic [COORD_W-1:0]        y_out,
  output logic signed [TOTAL_W-1:0] total_out,
  output logic [AMP_W-1:0]          amp_out,
  output logic                      run_out
);
  import fgn_pkg::*;

  localparam int unsigned LAT       = 12;
  localparam int unsigned SIDE_LAST = LAT - 2;

  typedef struct packed {
    logic [COORD_W-1:0]        x;
    logic [COORD_W-1:0]        y;
    logic signed [TOTAL_W-1:0] total;
    logic [AMP_W-1:0]          amp;
    logic                      act;
  } side_t;

  logic [31:0] xi;
  logic [31:0] yi;
  logic [31:0] base;
  logic [15:0] kx_in;
  logic [15:0] ky_in;
  logic        act_in;

  side_t       side [SIDE_LAST+1];
  logic        vld  [LAT];

  logic [31:0] idx [8];
  logic [15:0] kxd [4];
  logic [15:0] kyd [4];

  logic signed [GRAD_W-1:0] grad [8];
  logic [FADE_W-1:0]        kf   [4];
  logic [FADE_W-1:0]        fd   [4];
  logic [FADE_W-1:0]        fdl  [4][4];

  logic signed [16:0]        dxs [2];
  logic signed [16:0]        dys [2];
  logic signed [34:0]        px  [4];
  logic signed [34:0]        py  [4];
  logic signed [NOISE_W-1:0] v   [4];
  logic signed [37:0]        mp  [4];
  logic signed [NOISE_W-1:0] mx  [2];
  logic signed [37:0]        np  [2];
  logic signed [NOISE_W-1:0] noise;
  logic signed [AMP_W+20:0]  ap;
  logic [AMP_W+16:0]         pp;

  // Lattice cell and fraction of the scaled coordinate
  assign xi   = x_in[FRAC_BITS +: 32];
  assign yi   = y_in[FRAC_BITS +: 32];
  assign base = xi + (yi << ROW_SHIFT);

  if (FRAC_BITS >= 16) begin : g_frac_dn
    assign kx_in = x_in[FRAC_BITS-1 -: 16];
    assign ky_in = y_in[FRAC_BITS-1 -: 16];
  end else begin : g_frac_up
    assign kx_in = {x_in[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
    assign ky_in = {y_in[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
  end

  assign act_in = run_in && (4'(IDX) < octave_count) && (amp_in > AMP_W'(AMP_MIN));

  // Entry stage
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        idx[c]   <= base + CORNER_OFS[c];
        idx[c+4] <= base + CORNER_OFS[c] + GRAD_Y_OFS;
      end
      kxd[0] <= kx_in;
      kyd[0] <= ky_in;
      for (int s = 1; s < 4; s++) begin
        kxd[s] <= kxd[s-1];
        kyd[s] <= kyd[s-1];
      end
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_hash
    fgn_hash u_hash (
      .clk  (clk),
      .adv  (adv),
      .idx  (idx[g]),
      .grad (grad[g])
    );
  end

  assign kf[0] = FADE_W'(ONE_Q16) - {1'b0, kxd[0]};
  assign kf[1] = {1'b0, kxd[0]};
  assign kf[2] = FADE_W'(ONE_Q16) - {1'b0, kyd[0]};
  assign kf[3] = {1'b0, kyd[0]};

  for (genvar g = 0; g < 4; g++) begin : g_fade
    fgn_fade u_fade (
      .clk (clk),
      .adv (adv),
      .k   (kf[g]),
      .f   (fd[g])
    );
  end

  // Offsets to the near and far corners
  assign dxs[0] = $signed({1'b0, kxd[3]});
  assign dxs[1] = $signed({1'b1, kxd[3]});
  assign dys[0] = $signed({1'b0, kyd[3]});
  assign dys[1] = $signed({1'b1, kyd[3]});

  // Dot products, blends, weighting
  always_ff @(posedge clk) begin
    if (adv) begin
      fdl[0] <= fd;
      for (int s = 1; s < 4; s++) fdl[s] <= fdl[s-1];
      for (int c = 0; c < 4; c++) begin
        px[c] <= dxs[c & 1] * grad[c];
        py[c] <= dys[c >> 1] * grad[c+4];
        v[c]  <= NOISE_W'((36'(px[c]) + 36'(py[c])) >>> 16);
        mp[c] <= v[c] * $signed({1'b0, fdl[1][c & 1]});
      end
      for (int m = 0; m < 2; m++) begin
        mx[m] <= NOISE_W'((39'(mp[2*m]) + 39'(mp[2*m+1])) >>> 16);
        np[m] <= mx[m] * $signed({1'b0, fdl[3][m+2]});
      end
      noise <= NOISE_W'((39'(np[0]) + 39'(np[1])) >>> 16);
      ap    <= $signed({1'b0, side[SIDE_LAST-1].amp}) * noise;
      pp    <= side[SIDE_LAST-1].amp * persistence;
    end
  end

  // Side data rides alongside the noise pipe
  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= '{x: x_in, y: y_in, total: total_in, amp: amp_in, act: act_in};
      for (int s = 1; s <= SIDE_LAST; s++) side[s] <= side[s-1];
      x_out   <= {side[SIDE_LAST].x[COORD_W-2:0], 1'b0};
      y_out   <= {side[SIDE_LAST].y[COORD_W-2:0], 1'b0};
      run_out <= side[SIDE_LAST].act;
      if (side[SIDE_LAST].act) begin
        total_out <= side[SIDE_LAST].total + TOTAL_W'(ap >>> 16);
        amp_out   <= pp[AMP_W+15:16];
      end else begin
        total_out <= side[SIDE_LAST].total;
        amp_out   <= side[SIDE_LAST].amp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < LAT; s++) vld[s] <= 1'b0;
    end else if (adv) begin
      vld[0] <= valid_in;
      for (int s = 1; s < LAT; s++) vld[s] <= vld[s-1];
    end
  end

  assign valid_out = vld[LAT-1];

endmodule

// ----- tb/sv/fractal_gradient_noise_2d_unit_test.sv -----
// Self-checking testbench for the fractal gradient noise unit.
module fractal_gradient_noise_2d_unit_test;
  import fgn_pkg::*;

  // Indexes past the register list; the unit must ignore writes to them.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;
  // Drain wait once the queue is empty, covering every stage of the unit plus a margin.
  localparam int DRAIN_CYCLES = 12 * MAX_OCTAVES_DEF + 3 + 10;

  // Predicts each noise word and holds the expected results in order.
  class noise_scoreboard;
    res_t  pending[$];
    int    n_bad;
    bit [16:0] persist;
    bit [3:0]  octaves;

    function new();
      persist = PERSIST_RESET;
      octaves = OCTAVES_RESET;
      n_bad   = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_PERSISTENCE) persist = val;
      else if (idx == CFG_OCTAVE_COUNT) octaves = val[3:0];
    endfunction

    function longint lattice_grad(bit [31:0] n);
      bit [31:0] h;
      n = (n << 13) ^ n;
      h = n * (n * n * HASH_MUL + HASH_ADD) + HASH_OFS;
      return longint'(ONE_Q16) - longint'((h & 32'h7fffffff) >> 14);
    endfunction

    // quintic fade 6k^5 - 15k^4 + 10k^3, floor at each step
    function longint quintic(longint k);
      longint k2, k3, t;
      k2 = (k * k) >>> 16;
      k3 = (k2 * k) >>> 16;
      t  = (((6 * k - 15 * longint'(ONE_Q16)) * k) >>> 16) + 10 * longint'(ONE_Q16);
      return (k3 * t) >>> 16;
    endfunction

    function longint blend(longint a, longint b, longint k);
      return (a * quintic(longint'(ONE_Q16) - k) + b * quintic(k)) >>> 16;
    endfunction

    function longint corner_dot(bit [31:0] xi, bit [31:0] yi, longint dx, longint dy);
      bit [31:0] idx;
      idx = xi + yi * 32'd1024;
      return (dx * lattice_grad(idx) + dy * lattice_grad(idx + GRAD_Y_OFS)) >>> 16;
    endfunction

    function longint octave_noise(bit [63:0] sx, bit [63:0] sy);
      bit [31:0] xi, yi;
      longint kx, ky, v1, v2, v3, v4;
      xi = sx[47:16];
      yi = sy[47:16];
      kx = longint'(sx[15:0]);
      ky = longint'(sy[15:0]);
      v1 = corner_dot(xi, yi, kx, ky);
      v2 = corner_dot(xi + 1, yi, kx - ONE_Q16, ky);
      v3 = corner_dot(xi, yi + 1, kx, ky - ONE_Q16);
      v4 = corner_dot(xi + 1, yi + 1, kx - ONE_Q16, ky - ONE_Q16);
      return blend(blend(v1, v2, kx), blend(v3, v4, kx), ky);
    endfunction

    // accepted point: work out its result and queue it
    function void note_point(pt_t p);
      bit [63:0] x, y;
      longint total, amp, s;
      int limit;
      res_t r;
      x = p.x_coord;
      y = p.y_coord;
      total = 0;
      amp = ONE_Q16;
      limit = (octaves > MAX_OCTAVES_DEF) ? MAX_OCTAVES_DEF : octaves;
      for (int i = 0; i < limit && amp * 1000 > ONE_Q16; i++) begin
        total += (amp * octave_noise(x << i, y << i)) >>> 16;
        amp = (amp * persist) >> 16;
      end
      if (total > TOTAL_LIMIT) total = TOTAL_LIMIT;
      if (total < -TOTAL_LIMIT) total = -TOTAL_LIMIT;
      s = (total + ONE_Q16) * SHADE_SCALE;
      if (s < 0) s = 0;
      else begin
        s = s >>> 16;
        if (s > SHADE_MAX) s = SHADE_MAX;
      end
      r.noise_total = total[21:0];
      r.shade = s[7:0];
      pending.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result total=%0d shade=%0d", $time,
                 got.noise_total, got.shade);
        n_bad++;
        return;
      end
      want = pending.pop_front();
      if (got.noise_total !== want.noise_total) begin
        $display("%0t: noise_total expected %0d got %0d", $time,
                 want.noise_total, got.noise_total);
        n_bad++;
      end
      if (got.shade !== want.shade) begin
        $display("%0t: shade expected %0d got %0d", $time, want.shade, got.shade);
        n_bad++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pt_valid = 1'b0;
  logic pt_ready;
  pt_t  pt = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  noise_scoreboard sb = new();
  bit no_gaps = 1'b0;  // set for back-to-back stretches on both sides

  fractal_gradient_noise_2d_unit u_dut (
    .clk(clk), .rst(rst),
    .pt_valid(pt_valid), .pt_ready(pt_ready), .pt(pt),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Send one point; valid is only dropped when a gap follows, so it is never
  // lowered and raised in the same step.
  task automatic send_point(input pt_t p);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      pt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt       <= p;
    pt_valid <= 1'b1;
    do @(posedge clk); while (!pt_ready);
    sb.note_point(p);
  endtask

  task automatic send_xy(input logic [31:0] x, input logic [31:0] y);
    pt_t p;
    p.x_coord = x;
    p.y_coord = y;
    send_point(p);
  endtask

  // Sender holds off until every result is back, then the row is left to empty.
  task automatic drain();
    pt_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Mostly small lattice positions with random fractions, some full-range words.
  task automatic random_points(input int n);
    logic [31:0] x, y;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        x = $urandom();
        y = $urandom();
      end else begin
        x = {16'($urandom_range(0, 64)), 16'($urandom())};
        y = {16'($urandom_range(0, 64)), 16'($urandom())};
      end
      send_xy(x, y);
    end
  endtask

  // Result side: random stall per word, or none in back-to-back stretches.
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      sb.check_result(res);
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed points under reset settings: range corners, then three more.
    send_xy(32'h0, 32'h0);
    send_xy(32'hffff_ffff, 32'hffff_ffff);
    send_xy(32'hffff_ffff, 32'h0);
    send_xy(32'h0, 32'hffff_ffff);
    send_xy(32'h0000_ffff, 32'h0000_8000);
    send_xy(32'h0001_0000, 32'h0003_4000);
    send_xy(32'haaaa_5555, 32'h5555_aaaa);
    drain();

    // Zero octaves: sum must be zero, shade the midpoint.
    write_reg(CFG_OCTAVE_COUNT, 17'd0);
    send_xy(32'h0002_1234, 32'h0007_abcd);
    send_xy(32'hffff_ffff, 32'h8000_0001);
    drain();

    // Persistence of exactly 1.0, octave count above the cell count.
    write_reg(CFG_PERSISTENCE, 17'd65536);
    write_reg(CFG_OCTAVE_COUNT, 17'd15);
    send_xy(32'h0000_8000, 32'h0000_8000);
    send_xy(32'h1234_5678, 32'h9abc_def0);
    drain();

    // Persistence above 1.0: amplitude grows, total should saturate.
    write_reg(CFG_PERSISTENCE, 17'h1ffff);
    write_reg(CFG_OCTAVE_COUNT, 17'd8);
    send_xy(32'h0003_c000, 32'h0001_4000);
    send_xy(32'h0000_4000, 32'h0000_c000);
    send_xy(32'h7fff_ffff, 32'h0000_0001);
    drain();

    // Persistence zero cuts off after the first octave; spare indexes ignored.
    write_reg(CFG_PERSISTENCE, 17'd0);
    write_reg(CFG_SPARE_A, 17'h1ffff);
    write_reg(CFG_SPARE_B, 17'd5);
    send_xy(32'h0004_2000, 32'h0009_e000);
    send_xy(32'hffff_0000, 32'h0000_ffff);
    drain();

    // Random phases across several settings.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_PERSISTENCE, PERSIST_RESET);
          write_reg(CFG_OCTAVE_COUNT, 17'd8);
        end
        1: begin
          write_reg(CFG_PERSISTENCE, 17'd32768);
          write_reg(CFG_OCTAVE_COUNT, 17'd4);
        end
        2: write_reg(CFG_PERSISTENCE, 17'd65536);
        3: begin
          write_reg(CFG_PERSISTENCE, 17'd1000);
          write_reg(CFG_OCTAVE_COUNT, 17'd8);
        end
        4: write_reg(CFG_PERSISTENCE, 17'h1ffff);
        default: begin
          write_reg(CFG_PERSISTENCE, 17'($urandom_range(0, 17'h1ffff)));
          write_reg(CFG_OCTAVE_COUNT, 17'($urandom_range(0, 15)));
        end
      endcase
      no_gaps = (ph == 2 || ph == 6);
      random_points(120);
      no_gaps = 1'b0;
      drain();
    end

    if (sb.n_bad == 0 && sb.pending.size() == 0) begin
      $display("** fractal_gradient_noise_2d_unit: PASSED **");
    end else begin
      $display("** fractal_gradient_noise_2d_unit: FAILED **");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("** fractal_gradient_noise_2d_unit: FAILED **");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/fgn_pkg.sv
rtl/fgn_hash.sv
rtl/fgn_fade.sv
rtl/fgn_cell.sv
rtl/fractal_gradient_noise_2d_unit.sv
tb/sv/fractal_gradient_noise_2d_unit_test.sv
